FILE: sv/wig_pkg.sv
package wig_pkg;

  // Field widths of the request and result words
  localparam int GROUP_NUM_W  = 32;
  localparam int WAVE_IDX_W   = 4;
  localparam int GROUP_XY_W   = 16;
  localparam int COORD_W      = 32;
  localparam int LOCAL_XY_W   = 10;
  localparam int LOCAL_Z_W    = 6;
  localparam int FLAT_W       = 42;
  localparam int MASK_W       = 64;

  // Configuration register widths
  localparam int LS_XY_W      = 11;
  localparam int LS_Z_W       = 7;
  localparam int GC_W         = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 3;

  // Upper clamps of the local sizes
  localparam logic [LS_XY_W-1:0] LS_XY_MAX = 11'd1024;
  localparam logic [LS_Z_W-1:0]  LS_Z_MAX  = 7'd64;

  // Shared divider: 32-bit dividend, 16-bit divisor
  localparam int DIV_W        = 32;
  localparam int DVS_W        = 16;

  // Products: x*y local size, and full items per group
  localparam int XY_W         = 2 * LS_XY_W - 1;
  localparam int ITEMS_W      = XY_W + LS_Z_W - 1;
  localparam int MUL_A_W      = 32;
  localparam int MUL_B_W      = ITEMS_W;
  localparam int MUL_P_W      = MUL_A_W + MUL_B_W;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_SIZE_X  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_SIZE_Y  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_SIZE_Z  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_COUNT_X = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_COUNT_Y = 3'd4;

  typedef struct packed {
    logic [GROUP_NUM_W-1:0] group_number;
    logic [WAVE_IDX_W-1:0]  wave_index;
  } wig_in_t;

  typedef struct packed {
    logic [GROUP_XY_W-1:0] group_x;
    logic [GROUP_XY_W-1:0] group_y;
    logic [COORD_W-1:0]    group_z;
    logic [LOCAL_XY_W-1:0] local_x;
    logic [LOCAL_XY_W-1:0] local_y;
    logic [LOCAL_Z_W-1:0]  local_z;
    logic [COORD_W-1:0]    global_x;
    logic [COORD_W-1:0]    global_y;
    logic [COORD_W-1:0]    global_z;
    logic [FLAT_W-1:0]     flat_global_id;
    logic [MASK_W-1:0]     lane_mask;
    logic                  last;
  } wig_out_t;

endpackage

FILE: sv/wig_div.sv
module wig_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [wig_pkg::DIV_W-1:0] dividend,
  input  logic [wig_pkg::DVS_W-1:0] divisor,
  output logic                     done,
  output logic [wig_pkg::DIV_W-1:0] quotient,
  output logic [wig_pkg::DVS_W-1:0] remainder
);
  import wig_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try the subtract
  assign trial = {remainder, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Sequence the 32 steps and pulse done once the result is final
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_LAST);
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Hold partial remainder and quotient, advance one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (running) begin
      if (fits) begin
        remainder <= DVS_W'(trial - {1'b0, dvs});
      end else begin
        remainder <= trial[DVS_W-1:0];
      end
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

FILE: sv/workgroup_id_generator_unit.sv
// Work-group / work-item ID generator.
// Request channel: a word (group_number, wave_index) is taken on a clock
// edge with start high and busy low; busy stays high while the request is
// worked on. Configuration writes (cfg_we, cfg_index, cfg_data) set the
// local sizes and grid group counts; the user must make them only while
// busy is low, as the block itself does not enforce it. Result channel:
// one word per work-item of the chosen wavefront, x-fastest, each shown for
// one cycle with result_valid high; the wavefront's words come in
// consecutive cycles and the final one carries last. The receiver cannot
// stall, so words are never held back. Sharing: the group and local
// coordinates come from one shared shift-subtract divider, one quotient bit
// a cycle, used four times; one shared multiplier forms sizes and bases.
// After the divisions and the base products, one word comes out a cycle
// for each of the N work-items (N up to WAVE_SIZE).
// A request with too large a group or a wavefront past the group gives no
// word and frees busy after the size check.
// Reset: all sizes and counts return to 1, the sequencer to idle, and no
// word is shown.
module workgroup_id_generator_unit #(
  parameter int WAVE_SIZE       = 64,
  parameter int MAX_GROUP_ITEMS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  wig_pkg::wig_in_t               request,
  output logic                           result_valid,
  output wig_pkg::wig_out_t              result,
  input  logic                           cfg_we,
  input  logic [wig_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wig_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wig_pkg::*;

  localparam int CNT_W   = $clog2(WAVE_SIZE + 1);
  localparam int FIRST_W = WAVE_IDX_W + CNT_W;
  localparam int LID_W   = $clog2(MAX_GROUP_ITEMS);

  // Sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MXY    = 4'd1;
  localparam logic [3:0] S_MITEMS = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_DIV1   = 4'd4;
  localparam logic [3:0] S_DIV2   = 4'd5;
  localparam logic [3:0] S_DIV3   = 4'd6;
  localparam logic [3:0] S_DIV4   = 4'd7;
  localparam logic [3:0] S_MBX    = 4'd8;
  localparam logic [3:0] S_MBY    = 4'd9;
  localparam logic [3:0] S_MBZ    = 4'd10;
  localparam logic [3:0] S_MFLAT  = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  // Configuration registers
  logic [LS_XY_W-1:0] local_size_x;
  logic [LS_XY_W-1:0] local_size_y;
  logic [LS_Z_W-1:0]  local_size_z;
  logic [GC_W-1:0]    group_count_x;
  logic [GC_W-1:0]    group_count_y;

  // Effective sizes after clamping
  logic [LS_XY_W-1:0] lsx_c;
  logic [LS_XY_W-1:0] lsy_c;
  logic [LS_Z_W-1:0]  lsz_c;
  logic [GC_W-1:0]    gcx_c;
  logic [GC_W-1:0]    gcy_c;

  // Per-request working registers
  logic [GROUP_NUM_W-1:0] num;
  logic [WAVE_IDX_W-1:0]  wave;
  logic [XY_W-1:0]        xy;
  logic [ITEMS_W-1:0]     items;
  logic [GROUP_XY_W-1:0]  gx;
  logic [GROUP_XY_W-1:0]  gy;
  logic [COORD_W-1:0]     gz;
  logic [LOCAL_XY_W-1:0]  lx;
  logic [LOCAL_XY_W-1:0]  ly;
  logic [LOCAL_Z_W-1:0]   lz;
  logic [LID_W-1:0]       lid;
  logic [COORD_W-1:0]     base_x;
  logic [COORD_W-1:0]     base_y;
  logic [COORD_W-1:0]     base_z;
  logic [FLAT_W-1:0]      flat_base;
  logic [CNT_W-1:0]       remain;
  logic [MASK_W-1:0]      mask;

  logic [FIRST_W-1:0]     first;
  logic [ITEMS_W-1:0]     items_left;
  logic                   accept;
  logic                   wave_ok;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [DVS_W-1:0]   div_rem;

  logic [LS_XY_W-1:0] lx_inc;
  logic [LS_XY_W-1:0] ly_inc;
  logic               wrap_x;
  logic               wrap_y;
  logic [MASK_W-1:0]  mask_next;

  assign accept = start && !busy;
  assign busy   = state != S_IDLE;

  // Store configuration words; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      local_size_x  <= LS_XY_W'(1);
      local_size_y  <= LS_XY_W'(1);
      local_size_z  <= LS_Z_W'(1);
      group_count_x <= GC_W'(1);
      group_count_y <= GC_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCAL_SIZE_X:  local_size_x  <= cfg_data[LS_XY_W-1:0];
        REG_LOCAL_SIZE_Y:  local_size_y  <= cfg_data[LS_XY_W-1:0];
        REG_LOCAL_SIZE_Z:  local_size_z  <= cfg_data[LS_Z_W-1:0];
        REG_GROUP_COUNT_X: group_count_x <= cfg_data[GC_W-1:0];
        REG_GROUP_COUNT_Y: group_count_y <= cfg_data[GC_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one; oversized local sizes saturate
  always_comb begin
    lsx_c = (local_size_x == '0) ? LS_XY_W'(1) :
            (local_size_x > LS_XY_MAX) ? LS_XY_MAX : local_size_x;
    lsy_c = (local_size_y == '0) ? LS_XY_W'(1) :
            (local_size_y > LS_XY_MAX) ? LS_XY_MAX : local_size_y;
    lsz_c = (local_size_z == '0) ? LS_Z_W'(1) :
            (local_size_z > LS_Z_MAX) ? LS_Z_MAX : local_size_z;
    gcx_c = (group_count_x == '0) ? GC_W'(1) : group_count_x;
    gcy_c = (group_count_y == '0) ? GC_W'(1) : group_count_y;
  end

  // First local index of the wavefront and how many group items lie from it on
  assign first      = FIRST_W'(wave) * FIRST_W'(WAVE_SIZE);
  assign items_left = items - ITEMS_W'(first);
  assign wave_ok    = (items <= ITEMS_W'(MAX_GROUP_ITEMS)) && (ITEMS_W'(first) < items);

  // Shared multiplier, operands picked by the sequencer
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MXY: begin
        mul_a = MUL_A_W'(lsx_c);
        mul_b = MUL_B_W'(lsy_c);
      end
      S_MITEMS: begin
        mul_a = MUL_A_W'(xy);
        mul_b = MUL_B_W'(lsz_c);
      end
      S_MBX: begin
        mul_a = MUL_A_W'(gx);
        mul_b = MUL_B_W'(lsx_c);
      end
      S_MBY: begin
        mul_a = MUL_A_W'(gy);
        mul_b = MUL_B_W'(lsy_c);
      end
      S_MBZ: begin
        mul_a = gz;
        mul_b = MUL_B_W'(lsz_c);
      end
      S_MFLAT: begin
        mul_a = num;
        mul_b = items;
      end
      default: ;
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Divider operands: group split first, then the wavefront's first local index
  always_comb begin
    div_dividend = '0;
    div_divisor  = DVS_W'(1);
    unique case (state)
      S_CHECK: begin
        div_dividend = num;
        div_divisor  = gcx_c;
      end
      S_DIV1: begin
        div_dividend = div_quo;
        div_divisor  = gcy_c;
      end
      S_DIV2: begin
        div_dividend = DIV_W'(first);
        div_divisor  = DVS_W'(lsx_c);
      end
      S_DIV3: begin
        div_dividend = div_quo;
        div_divisor  = DVS_W'(lsy_c);
      end
      default: ;
    endcase
  end

  assign div_start = ((state == S_CHECK) && wave_ok) ||
                     (((state == S_DIV1) || (state == S_DIV2) || (state == S_DIV3)) &&
                      div_done);

  wig_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_MXY;
      S_MXY:    state_next = S_MITEMS;
      S_MITEMS: state_next = S_CHECK;
      S_CHECK:  state_next = wave_ok ? S_DIV1 : S_IDLE;
      S_DIV1:   if (div_done) state_next = S_DIV2;
      S_DIV2:   if (div_done) state_next = S_DIV3;
      S_DIV3:   if (div_done) state_next = S_DIV4;
      S_DIV4:   if (div_done) state_next = S_MBX;
      S_MBX:    state_next = S_MBY;
      S_MBY:    state_next = S_MBZ;
      S_MBZ:    state_next = S_MFLAT;
      S_MFLAT:  state_next = S_EMIT;
      S_EMIT:   if (remain == CNT_W'(1)) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= state == S_EMIT;
    end
  end

  // Local position carries: x fastest, then y, then z
  assign lx_inc    = {1'b0, lx} + LS_XY_W'(1);
  assign ly_inc    = {1'b0, ly} + LS_XY_W'(1);
  assign wrap_x    = lx_inc == lsx_c;
  assign wrap_y    = ly_inc == lsy_c;
  assign mask_next = {mask[MASK_W-2:0], 1'b1};

  // Working registers and the result word
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          num <= request.group_number;
          wave <= request.wave_index;
        end
      end
      S_MXY:    xy <= XY_W'(mul_p);
      S_MITEMS: items <= ITEMS_W'(mul_p);
      S_CHECK: begin
        mask <= '0;
        if (items_left > ITEMS_W'(WAVE_SIZE)) begin
          remain <= CNT_W'(WAVE_SIZE);
        end else begin
          remain <= CNT_W'(items_left);
        end
      end
      S_DIV1: if (div_done) gx <= div_rem;
      S_DIV2: begin
        if (div_done) begin
          gy <= div_rem;
          gz <= div_quo;
        end
      end
      S_DIV3: if (div_done) lx <= div_rem[LOCAL_XY_W-1:0];
      S_DIV4: begin
        if (div_done) begin
          ly  <= div_rem[LOCAL_XY_W-1:0];
          lz  <= div_quo[LOCAL_Z_W-1:0];
          lid <= LID_W'(first);
        end
      end
      S_MBX:   base_x <= COORD_W'(mul_p);
      S_MBY:   base_y <= COORD_W'(mul_p);
      S_MBZ:   base_z <= COORD_W'(mul_p);
      S_MFLAT: flat_base <= FLAT_W'(mul_p);
      S_EMIT: begin
        result.group_x        <= gx;
        result.group_y        <= gy;
        result.group_z        <= gz;
        result.local_x        <= lx;
        result.local_y        <= ly;
        result.local_z        <= lz;
        result.global_x       <= base_x + COORD_W'(lx);
        result.global_y       <= base_y + COORD_W'(ly);
        result.global_z       <= base_z + COORD_W'(lz);
        result.flat_global_id <= flat_base + FLAT_W'(lid);
        result.lane_mask      <= mask_next;
        result.last           <= remain == CNT_W'(1);
        mask   <= mask_next;
        remain <= remain - CNT_W'(1);
        lid    <= lid + LID_W'(1);
        // advance the local position
        if (wrap_x) begin
          lx <= '0;
          if (wrap_y) begin
            ly <= '0;
            lz <= lz + LOCAL_Z_W'(1);
          end else begin
            ly <= ly_inc[LOCAL_XY_W-1:0];
          end
        end else begin
          lx <= lx_inc[LOCAL_XY_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/wig_checker.sv
module wig_port_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input wig_pkg::wig_out_t result
);
  import wig_pkg::*;

  // A taken request always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // Words only follow work in progress
  a_word_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result word without a request in progress");

  // A wavefront's words come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |=> result_valid)
    else $error("gap inside a wavefront");

  // Nothing follows straight after the final word
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("word straight after the final word");

  // Lane mask grows by one lane per word
  a_mask_grows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(result_valid)) |->
      (result.lane_mask == {$past(result.lane_mask[MASK_W-2:0]), 1'b1}))
    else $error("lane mask did not grow by one lane");

endmodule

bind workgroup_id_generator_unit wig_port_checker u_wig_checker (.*);

FILE: tb/wig_checker.sv
module wig_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  wig_pkg::wig_in_t                request,
  input  logic                            result_valid,
  input  wig_pkg::wig_out_t               result,
  input  logic                            cfg_we,
  input  logic [wig_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wig_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              errors,
  output int                              pending
);
  import wig_pkg::*;

  localparam int WAVE_SIZE       = 64;
  localparam int MAX_GROUP_ITEMS = 1024;

  // Shadow copy of the size and grid registers
  logic [LS_XY_W-1:0] ls_x, ls_y;
  logic [LS_Z_W-1:0]  ls_z;
  logic [GC_W-1:0]    gc_x, gc_y;

  wig_out_t awaited_words[$];
  wig_out_t head_word;
  int       n_fail = 0;
  int       n_pending = 0;

  assign errors  = n_fail;
  assign pending = n_pending;

  // Zero acts as one; anything past the upper bound sticks at the bound
  function automatic longint unsigned eff_size(longint unsigned v, longint unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Queue every work-item word of the requested wavefront
  function automatic void expand_wavefront(wig_in_t req);
    longint unsigned sx, sy, sz, cx, cy, num, items, first, count;
    longint unsigned gx, gy, gz, lid, lx, ly, lz, k;
    logic [MASK_W-1:0] lanes;
    wig_out_t w;
    sx    = eff_size(64'(ls_x), 64'(LS_XY_MAX));
    sy    = eff_size(64'(ls_y), 64'(LS_XY_MAX));
    sz    = eff_size(64'(ls_z), 64'(LS_Z_MAX));
    cx    = (gc_x == '0) ? 64'd1 : 64'(gc_x);
    cy    = (gc_y == '0) ? 64'd1 : 64'(gc_y);
    num   = 64'(req.group_number);
    items = sx * sy * sz;
    first = 64'(req.wave_index) * 64'(WAVE_SIZE);
    // oversized group or wavefront past the group: nothing comes out
    if (items > 64'(MAX_GROUP_ITEMS) || first >= items) return;
    count = items - first;
    if (count > 64'(WAVE_SIZE)) count = 64'(WAVE_SIZE);
    gx = num % cx;
    gy = (num / cx) % cy;
    gz = num / (cx * cy);
    lanes = '0;
    for (k = 0; k < count; k++) begin
      lid = first + k;
      lx  = lid % sx;
      ly  = (lid / sx) % sy;
      lz  = lid / (sx * sy);
      lanes[k[5:0]] = 1'b1;
      w.group_x        = GROUP_XY_W'(gx);
      w.group_y        = GROUP_XY_W'(gy);
      w.group_z        = COORD_W'(gz);
      w.local_x        = LOCAL_XY_W'(lx);
      w.local_y        = LOCAL_XY_W'(ly);
      w.local_z        = LOCAL_Z_W'(lz);
      w.global_x       = COORD_W'(gx * sx + lx);
      w.global_y       = COORD_W'(gy * sy + ly);
      w.global_z       = COORD_W'(gz * sz + lz);
      w.flat_global_id = FLAT_W'(num * items + lid);
      w.lane_mask      = lanes;
      w.last           = (k + 1 == count);
      awaited_words.push_back(w);
    end
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      n_fail++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Sample both channels and the register port on each rising edge
  always @(posedge clk) begin
    if (rst) begin
      awaited_words.delete();
      ls_x = 1;
      ls_y = 1;
      ls_z = 1;
      gc_x = 1;
      gc_y = 1;
    end else begin
      // compare an emitted word with the oldest one awaited
      if (result_valid) begin
        if (awaited_words.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected word: expected none, got 0x%h", $time, result);
        end else begin
          head_word = awaited_words.pop_front();
          check_field("group_x", 64'(head_word.group_x), 64'(result.group_x));
          check_field("group_y", 64'(head_word.group_y), 64'(result.group_y));
          check_field("group_z", 64'(head_word.group_z), 64'(result.group_z));
          check_field("local_x", 64'(head_word.local_x), 64'(result.local_x));
          check_field("local_y", 64'(head_word.local_y), 64'(result.local_y));
          check_field("local_z", 64'(head_word.local_z), 64'(result.local_z));
          check_field("global_x", 64'(head_word.global_x), 64'(result.global_x));
          check_field("global_y", 64'(head_word.global_y), 64'(result.global_y));
          check_field("global_z", 64'(head_word.global_z), 64'(result.global_z));
          check_field("flat_global_id", 64'(head_word.flat_global_id),
                      64'(result.flat_global_id));
          check_field("lane_mask", head_word.lane_mask, result.lane_mask);
          check_field("last", 64'(head_word.last), 64'(result.last));
        end
      end
      // track register writes; unknown indexes fall through
      if (cfg_we) begin
        case (cfg_index)
          REG_LOCAL_SIZE_X:  ls_x = cfg_data[LS_XY_W-1:0];
          REG_LOCAL_SIZE_Y:  ls_y = cfg_data[LS_XY_W-1:0];
          REG_LOCAL_SIZE_Z:  ls_z = cfg_data[LS_Z_W-1:0];
          REG_GROUP_COUNT_X: gc_x = cfg_data[GC_W-1:0];
          REG_GROUP_COUNT_Y: gc_y = cfg_data[GC_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) expand_wavefront(request);
    end
    n_pending = awaited_words.size();
  end

endmodule

FILE: tb/tb.sv
module tb;
  import wig_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  wig_in_t                request = '0;
  logic                   result_valid;
  wig_out_t               result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     errors, pending;
  logic                   taken = 1'b0;
  int                     quiet_cycles = 0;
  int                     n_waves = 1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  workgroup_id_generator_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  wig_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  // Note request acceptance; drop the run if nothing moves for too long
  always @(posedge clk) begin
    taken <= start && !busy && !rst;
    if (rst || (start && !busy) || result_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request word and hold it until the block takes it
  task automatic send(logic [GROUP_NUM_W-1:0] num, logic [WAVE_IDX_W-1:0] wave);
    start   <= 1'b1;
    request <= '{group_number: num, wave_index: wave};
    do @(negedge clk); while (!taken);
  endtask

  // Hold off until every awaited word is out and the block is free
  task automatic wait_idle();
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Rewrite all registers, with a stray write to an unused index first
  task automatic set_config(logic [CFG_DATA_W-1:0] sx, logic [CFG_DATA_W-1:0] sy,
                            logic [CFG_DATA_W-1:0] sz, logic [CFG_DATA_W-1:0] cx,
                            logic [CFG_DATA_W-1:0] cy);
    longint prod;
    wait_idle();
    put_reg(CFG_INDEX_W'($urandom_range(REG_GROUP_COUNT_Y + 1, (1 << CFG_INDEX_W) - 1)),
            CFG_DATA_W'($urandom));
    put_reg(REG_LOCAL_SIZE_X, sx);
    put_reg(REG_LOCAL_SIZE_Y, sy);
    put_reg(REG_LOCAL_SIZE_Z, sz);
    put_reg(REG_GROUP_COUNT_X, cx);
    put_reg(REG_GROUP_COUNT_Y, cy);
    cfg_we <= 1'b0;
    // rough wavefront count, only to steer wave_index towards live wavefronts
    prod = longint'(sx) * longint'(sy) * longint'(sz);
    n_waves = (prod == 0 || prod > 1024) ? 16 : int'((prod + 63) / 64);
  endtask

  function automatic logic [GROUP_NUM_W-1:0] pick_number();
    case ($urandom_range(0, 9)) inside
      0:       return '0;
      1:       return '1;
      2, 3:    return GROUP_NUM_W'($urandom_range(0, 4096));
      default: return GROUP_NUM_W'($urandom);
    endcase
  endfunction

  function automatic logic [WAVE_IDX_W-1:0] pick_wave();
    if ($urandom_range(0, 3) != 0) return WAVE_IDX_W'($urandom_range(0, n_waves - 1));
    return WAVE_IDX_W'($urandom);
  endfunction

  // Send words in bursts with random gaps; scramble the idle request bus
  task automatic run_items(int n);
    int left, burst, gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && left > 0) begin
        send(pick_number(), pick_wave());
        burst--;
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 180);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) begin
          request <= {$urandom, WAVE_IDX_W'($urandom)};
          @(negedge clk);
        end
      end
    end
    start <= 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] sx, sy, sz, cx, cy;
    sx = CFG_DATA_W'($urandom_range(1, 40));
    sy = CFG_DATA_W'($urandom_range(1, (1024 / sx < 40) ? 1024 / sx : 40));
    sz = CFG_DATA_W'($urandom_range(1, (1024 / (sx * sy) < 64) ? 1024 / (sx * sy) : 64));
    cx = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom_range(0, 8))
                                     : CFG_DATA_W'($urandom_range(1, 65535));
    cy = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom_range(0, 8))
                                     : CFG_DATA_W'($urandom_range(1, 65535));
    case ($urandom_range(0, 9))
      0: set_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      1: set_config(1024, 1, 1, cx, cy);
      2: set_config(1, 1024, 1, cx, cy);
      default: set_config(sx, sy, sz, cx, cy);
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset sizes: one work-item per group, later wavefronts empty
    send(0, 0);
    send('1, 0);
    send(5, 1);
    send(7, 15);
    start <= 1'b0;

    // one full wavefront on a small grid
    set_config(8, 8, 1, 3, 5);
    send(0, 0);
    send(14, 0);
    send(29, 1);
    send('1, 0);
    start <= 1'b0;

    // widest x and largest grid: last wavefront and global wrap
    set_config(1024, 1, 1, 65535, 65535);
    send('1, 15);
    send(65534, 0);
    start <= 1'b0;

    set_config(1, 1024, 1, 1, 65535);
    send(123456, 9);
    start <= 1'b0;

    // deepest z with zero group counts
    set_config(4, 4, 64, 0, 0);
    send('1, 15);
    send(1, 3);
    start <= 1'b0;

    // partial last wavefront, then one past the group
    set_config(5, 7, 3, 65535, 1);
    send(70000, 1);
    send(70000, 2);
    start <= 1'b0;

    // group too large
    set_config(1024, 2, 1, 2, 2);
    send(9, 0);
    start <= 1'b0;

    // zero sizes act as one, z above range clamps
    set_config(0, 0, 127, 0, 0);
    send(3, 0);
    start <= 1'b0;

    set_config(2047, 0, 0, 7, 0);
    send(100, 15);
    start <= 1'b0;

    // high data bits beyond each register are dropped
    set_config(16'hFFFF, 16'hF801, 16'h0080, 16'hFFFF, 16'h0000);
    send('1, 15);
    start <= 1'b0;

    repeat (12) begin
      random_config();
      run_items(25);
    end

    wait_idle();
    repeat (200) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
